/* hdl/dfp_pkg.sv */
// Package: shared types and constants for the distance frame parser.
`default_nettype none
package dfp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned DIST_W = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hFF;
  localparam logic [DIST_W-1:0] MIN_DIST_RESET = 16'd30;
  localparam logic [DIST_W-1:0] MAX_DIST_RESET = 16'd400;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_DIST = 1'b0,
    REG_MAX_DIST = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_CHECK = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CHECKSUM  = 2'd1,
    ST_ABOVE_MAX = 2'd2,
    ST_BELOW_MIN = 2'd3
  } status_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } byte_req_t;

endpackage
`default_nettype wire

/* hdl/dfp_in_stage.sv */
// Input register stage: captures one received byte per request.
`default_nettype none
module dfp_in_stage (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [dfp_pkg::BYTE_W-1:0] rx_byte,
  output dfp_pkg::byte_req_t              req,
  input  wire logic                       take
);

  dfp_pkg::byte_req_t held;

  assign in_stall = held.valid && !take;
  assign req      = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else if (!in_stall) begin
      held.valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      held.data <= rx_byte;
    end
  end

endmodule
`default_nettype wire

/* hdl/dfp_frame.sv */
// Frame tracker: header hunt, checksum, clamp and result register.
`default_nettype none
module dfp_frame (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire dfp_pkg::byte_req_t         req,
  output logic                            take,
  input  wire logic [dfp_pkg::DIST_W-1:0] min_distance,
  input  wire logic [dfp_pkg::DIST_W-1:0] max_distance,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [dfp_pkg::DIST_W-1:0]      distance_out,
  output logic [1:0]                      frame_status
);

  dfp_pkg::phase_t               phase, phase_next;
  logic [dfp_pkg::BYTE_W-1:0]    high_byte, low_byte;
  logic [dfp_pkg::DIST_W-1:0]    held_distance, held_distance_next;
  dfp_pkg::status_t              status_next;
  logic [dfp_pkg::BYTE_W-1:0]    sum;
  logic [dfp_pkg::DIST_W-1:0]    cand;
  logic                          advance;
  logic                          finish;

  assign advance = !out_valid || !out_stall;
  assign take    = req.valid && ((phase != dfp_pkg::PH_CHECK) || advance);
  assign finish  = take && (phase == dfp_pkg::PH_CHECK);

  always_comb begin
    sum  = dfp_pkg::BYTE_W'(dfp_pkg::HEADER_BYTE + high_byte + low_byte);
    cand = held_distance;
    status_next = dfp_pkg::ST_CHECKSUM;
    if (sum == req.data) begin
      cand = {high_byte, low_byte};
      status_next = dfp_pkg::ST_OK;
    end
    held_distance_next = cand;
    if (cand > max_distance) begin
      held_distance_next = max_distance;
      status_next = dfp_pkg::ST_ABOVE_MAX;
    end else if (cand < min_distance) begin
      held_distance_next = min_distance;
      status_next = dfp_pkg::ST_BELOW_MIN;
    end
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      dfp_pkg::PH_HUNT: begin
        if (req.data == dfp_pkg::HEADER_BYTE) begin
          phase_next = dfp_pkg::PH_HIGH;
        end
      end
      dfp_pkg::PH_HIGH:  phase_next = dfp_pkg::PH_LOW;
      dfp_pkg::PH_LOW:   phase_next = dfp_pkg::PH_CHECK;
      dfp_pkg::PH_CHECK: phase_next = dfp_pkg::PH_HUNT;
      default:           phase_next = dfp_pkg::PH_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= dfp_pkg::PH_HUNT;
      high_byte     <= '0;
      low_byte      <= '0;
      held_distance <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (take) begin
        phase <= phase_next;
        if (phase == dfp_pkg::PH_HIGH) begin
          high_byte <= req.data;
        end
        if (phase == dfp_pkg::PH_LOW) begin
          low_byte <= req.data;
        end
      end
      if (finish) begin
        held_distance <= held_distance_next;
      end
      if (advance) begin
        out_valid <= finish;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      distance_out <= held_distance_next;
      frame_status <= status_next;
    end
  end

  a_hunt_drop: assert property (@(posedge clk) disable iff (rst)
    (take && phase == dfp_pkg::PH_HUNT && req.data != dfp_pkg::HEADER_BYTE)
      |=> (phase == dfp_pkg::PH_HUNT))
    else $error("non-header byte left the hunt phase");

  a_result_only_at_check: assert property (@(posedge clk) disable iff (rst)
    (advance && !finish) |=> !out_valid)
    else $error("result produced outside the checksum byte");

  a_held_matches_out: assert property (@(posedge clk) disable iff (rst)
    finish |=> (held_distance == distance_out))
    else $error("held distance differs from emitted distance");

  a_above_max: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_status == dfp_pkg::ST_ABOVE_MAX)
      |-> (distance_out == max_distance))
    else $error("above-max status without clamp to max");

  a_ok_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_status == dfp_pkg::ST_OK)
      |-> (distance_out <= max_distance && distance_out >= min_distance))
    else $error("ok status with distance outside limits");

endmodule
`default_nettype wire

/* hdl/distance_frame_parser_core.sv */
// Top level: distance frame parser with limit registers.
//
//   channel | handshake           | payload
//   --------+---------------------+----------------------------
//   in      | in_valid / in_stall | rx_byte
//   out     | out_valid/out_stall | distance_out, frame_status
//   cfg     | cfg_write           | cfg_index, cfg_data
//
// One byte is accepted per cycle unless in_stall is high; a frame's checksum
// byte passes the input register, then the result register holds its result.
// rst is synchronous: limits return to 30 and 400, the hunt restarts.
// A stalled result holds; the input keeps flowing for hunt, high and low
// bytes and stalls only when a checksum byte meets a full, stalled result register.
`default_nettype none
module distance_frame_parser_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [dfp_pkg::BYTE_W-1:0]    rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [dfp_pkg::DIST_W-1:0]         distance_out,
  output logic [1:0]                         frame_status,
  input  wire logic                          cfg_write,
  input  wire logic [dfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dfp_pkg::DIST_W-1:0]    cfg_data
);

  logic [dfp_pkg::DIST_W-1:0] min_distance;
  logic [dfp_pkg::DIST_W-1:0] max_distance;
  dfp_pkg::byte_req_t         req;
  logic                       take;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance <= dfp_pkg::MIN_DIST_RESET;
      max_distance <= dfp_pkg::MAX_DIST_RESET;
    end else if (cfg_write) begin
      case (dfp_pkg::reg_index_t'(cfg_index))
        dfp_pkg::REG_MIN_DIST: min_distance <= cfg_data;
        dfp_pkg::REG_MAX_DIST: max_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  dfp_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .req      (req),
    .take     (take)
  );

  dfp_frame u_frame (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .take         (take),
    .min_distance (min_distance),
    .max_distance (max_distance),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .distance_out (distance_out),
    .frame_status (frame_status)
  );

endmodule
`default_nettype wire

/* test/distance_frame_parser_core_tb.sv */
// Testbench for distance_frame_parser_core: random byte streams checked against a frame predictor.
module distance_frame_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dfp_pkg::*;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    status_t           status;
  } reading_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] rx_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DIST_W-1:0] distance_out;
  logic [1:0]        frame_status;
  logic              cfg_write = 1'b0;
  reg_index_t        cfg_index = REG_MIN_DIST;
  logic [DIST_W-1:0] cfg_data = '0;

  logic [BYTE_W-1:0] pending_bytes[$];
  reading_t          expected_readings[$];

  logic [DIST_W-1:0] lim_min = MIN_DIST_RESET;
  logic [DIST_W-1:0] lim_max = MAX_DIST_RESET;
  phase_t            parse_phase = PH_HUNT;
  logic [BYTE_W-1:0] frame_high = '0;
  logic [BYTE_W-1:0] frame_low = '0;
  logic [DIST_W-1:0] held_distance = '0;

  int idle_mode = 0;
  int error_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  distance_frame_parser_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .distance_out (distance_out),
    .frame_status (frame_status),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void track_sensor_byte(logic [BYTE_W-1:0] b);
    reading_t          r;
    logic [BYTE_W-1:0] sum;
    case (parse_phase)
      PH_HUNT: begin
        if (b == HEADER_BYTE) parse_phase = PH_HIGH;
      end
      PH_HIGH: begin
        frame_high = b;
        parse_phase = PH_LOW;
      end
      PH_LOW: begin
        frame_low = b;
        parse_phase = PH_CHECK;
      end
      default: begin
        parse_phase = PH_HUNT;
        sum = HEADER_BYTE + frame_high + frame_low;
        if (sum != b) begin
          r.status = ST_CHECKSUM;
        end else begin
          held_distance = {frame_high, frame_low};
          r.status = ST_OK;
        end
        if (held_distance > lim_max) begin
          r.status = ST_ABOVE_MAX;
          held_distance = lim_max;
        end else if (held_distance < lim_min) begin
          r.status = ST_BELOW_MIN;
          held_distance = lim_min;
        end
        r.distance = held_distance;
        expected_readings.push_back(r);
      end
    endcase
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) track_sensor_byte(rx_byte);
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() > 0 &&
            $urandom_range(99) >= (idle_mode == 0 ? 37 : idle_mode == 1 ? 67 : 0)) begin
          in_valid <= 1'b1;
          rx_byte  <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result stall, with one long hold once idling is off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (idle_mode == 2 && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 120;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < (idle_mode == 0 ? 67 : idle_mode == 1 ? 37 : 0));
    end
  end

  // result monitor
  always @(posedge clk) begin
    reading_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected result: distance_out %0d frame_status %0d", distance_out,
               frame_status);
        error_count++;
      end else begin
        want = expected_readings.pop_front();
        if (distance_out !== want.distance) begin
          $error("distance_out expected %0d actual %0d", want.distance, distance_out);
          error_count++;
        end
        if (frame_status !== want.status) begin
          $error("frame_status expected %0d actual %0d", want.status, frame_status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= 2000) begin
        $display("distance_frame_parser_core_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic write_limit(reg_index_t idx, logic [DIST_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == REG_MIN_DIST) lim_min = value;
    else lim_max = value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_until_idle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_readings.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic queue_frame(logic [DIST_W-1:0] d, bit corrupt);
    logic [BYTE_W-1:0] chk;
    chk = HEADER_BYTE + d[15:8] + d[7:0];
    if (corrupt) chk = chk ^ BYTE_W'($urandom_range(255, 1));
    pending_bytes.push_back(HEADER_BYTE);
    pending_bytes.push_back(d[15:8]);
    pending_bytes.push_back(d[7:0]);
    pending_bytes.push_back(chk);
  endtask

  task automatic queue_random_traffic(int frame_bytes);
    int                queued;
    logic [DIST_W-1:0] d;
    queued = 0;
    while (queued < frame_bytes) begin
      // drop non-header noise between frames
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(3, 1)) pending_bytes.push_back(BYTE_W'($urandom_range(254)));
      // raw byte that may shift the framing
      if ($urandom_range(19) == 0) begin
        pending_bytes.push_back(BYTE_W'($urandom_range(255)));
        queued++;
      end
      case ($urandom_range(4))
        0: d = DIST_W'($urandom_range(65535));
        1: d = lim_min + DIST_W'($urandom_range(4)) - 16'd2;
        2: d = lim_max + DIST_W'($urandom_range(4)) - 16'd2;
        3: d = DIST_W'($urandom_range(lim_min, lim_max));
        default: d = DIST_W'($urandom_range(600));
      endcase
      queue_frame(d, $urandom_range(9) == 0);
      queued += 4;
    end
  endtask

  initial begin
    logic [DIST_W-1:0] a;
    logic [DIST_W-1:0] b;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'h12);
    queue_frame(16'h0000, 1'b0);
    queue_frame(16'd300, 1'b0);
    queue_frame(16'hFFFF, 1'b0);
    queue_frame(16'h00FF, 1'b0);
    queue_frame(16'h0064, 1'b1);
    pending_bytes.push_back(8'h7E);
    wait_until_idle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin a = 16'h0000; b = 16'hFFFF; end
        1: begin a = 16'hFFFF; b = 16'h0000; end
        2: begin a = 16'd500;  b = 16'd100;  end
        3: begin
          a = DIST_W'($urandom_range(2000));
          b = a + DIST_W'($urandom_range(2000));
        end
        4: begin a = MIN_DIST_RESET; b = MAX_DIST_RESET; end
        default: begin
          a = DIST_W'($urandom_range(65535));
          b = DIST_W'($urandom_range(65535));
        end
      endcase
      write_limit(REG_MIN_DIST, a);
      write_limit(REG_MAX_DIST, b);
      @(negedge clk);
      idle_mode = p / 2;
      queue_random_traffic(225);
      wait_until_idle();
    end

    if (error_count == 0) begin
      $display("distance_frame_parser_core_tb: PASS");
    end else begin
      $display("distance_frame_parser_core_tb: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/dfp_pkg.sv
hdl/dfp_in_stage.sv
hdl/dfp_frame.sv
hdl/distance_frame_parser_core.sv
test/distance_frame_parser_core_tb.sv
